/* design/usb_cdc_control_request_handler_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the CDC control request handler
// Shared property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef USB_CDC_CONTROL_REQUEST_HANDLER_TOP_MACROS_SVH
`define USB_CDC_CONTROL_REQUEST_HANDLER_TOP_MACROS_SVH

// implication checked every clock, quiet in reset
`define UCRH_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UCRH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ucrh_pkg.sv */
// ----------------------------------------------------------------------------
// ucrh_pkg
// Types, request codes and descriptor tables for the control request handler.
// ----------------------------------------------------------------------------
package ucrh_pkg;

    localparam logic [1:0] KIND_IN     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_STALL  = 2'd2;
    localparam logic [1:0] KIND_RESET  = 2'd3;

    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_SET_LINE_CODE = 8'h20;
    localparam logic [7:0] REQ_GET_LINE_CODE = 8'h21;
    localparam logic [7:0] REQ_SET_CTRL_LINE = 8'h22;

    localparam logic [7:0] TYPE_STD_OUT   = 8'h00;
    localparam logic [7:0] TYPE_STD_IN    = 8'h80;
    localparam logic [7:0] TYPE_CLASS_IN  = 8'hA1;
    localparam logic [7:0] TYPE_CLASS_OUT = 8'h21;

    localparam logic [55:0] LINE_CODING_RESET = 56'h0800000000E100;
    localparam int IMAGE_BYTES   = 135;
    localparam int IMAGE_ENTRIES = 5;
    localparam int MAX_RESULTS   = 17;
    localparam int PKT_FIELD_BYTES = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FILL,
        ST_EMIT,
        ST_SINGLE
    } ucrh_state_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] offset;
        logic [7:0]  length;
        logic        valid;
    } ucrh_dir_t;

    function automatic logic [7:0] rom_image(input logic [9:0] a);
        logic [7:0] b;
        case (a)
            10'd0: b = 8'd18;   10'd1: b = 8'd1;    10'd2: b = 8'h00;  10'd3: b = 8'h02;
            10'd4: b = 8'd2;    10'd5: b = 8'd0;    10'd6: b = 8'd0;   10'd7: b = 8'd16;
            10'd8: b = 8'h41;   10'd9: b = 8'h23;   10'd10: b = 8'h41; 10'd11: b = 8'h80;
            10'd12: b = 8'h00;  10'd13: b = 8'h01;  10'd14: b = 8'd1;  10'd15: b = 8'd2;
            10'd16: b = 8'd0;   10'd17: b = 8'd1;
            10'd18: b = 8'd9;   10'd19: b = 8'd2;   10'd20: b = 8'd75; 10'd21: b = 8'd0;
            10'd22: b = 8'd2;   10'd23: b = 8'd1;   10'd24: b = 8'd0;  10'd25: b = 8'h80;
            10'd26: b = 8'hFA;
            10'd27: b = 8'd8;   10'd28: b = 8'h0B;  10'd29: b = 8'd0;  10'd30: b = 8'd2;
            10'd31: b = 8'd2;   10'd32: b = 8'd2;   10'd33: b = 8'd1;  10'd34: b = 8'd0;
            10'd35: b = 8'd9;   10'd36: b = 8'd4;   10'd37: b = 8'd0;  10'd38: b = 8'd0;
            10'd39: b = 8'd1;   10'd40: b = 8'h02;  10'd41: b = 8'h02; 10'd42: b = 8'h00;
            10'd43: b = 8'd0;
            10'd44: b = 8'd5;   10'd45: b = 8'h24;  10'd46: b = 8'h00; 10'd47: b = 8'h10;
            10'd48: b = 8'h01;
            10'd49: b = 8'd5;   10'd50: b = 8'h24;  10'd51: b = 8'h01; 10'd52: b = 8'h01;
            10'd53: b = 8'd1;
            10'd54: b = 8'd4;   10'd55: b = 8'h24;  10'd56: b = 8'h02; 10'd57: b = 8'h06;
            10'd58: b = 8'd5;   10'd59: b = 8'h24;  10'd60: b = 8'h06; 10'd61: b = 8'd0;
            10'd62: b = 8'd1;
            10'd63: b = 8'd7;   10'd64: b = 8'd5;   10'd65: b = 8'h82; 10'd66: b = 8'h03;
            10'd67: b = 8'd16;  10'd68: b = 8'd0;   10'd69: b = 8'd64;
            10'd70: b = 8'd9;   10'd71: b = 8'd4;   10'd72: b = 8'd1;  10'd73: b = 8'd0;
            10'd74: b = 8'd2;   10'd75: b = 8'h0A;  10'd76: b = 8'h00; 10'd77: b = 8'h00;
            10'd78: b = 8'd0;
            10'd79: b = 8'd7;   10'd80: b = 8'd5;   10'd81: b = 8'h03; 10'd82: b = 8'h02;
            10'd83: b = 8'd64;  10'd84: b = 8'd0;   10'd85: b = 8'd0;
            10'd86: b = 8'd7;   10'd87: b = 8'd5;   10'd88: b = 8'h84; 10'd89: b = 8'h02;
            10'd90: b = 8'd64;  10'd91: b = 8'd0;   10'd92: b = 8'd0;
            10'd93: b = 8'd4;   10'd94: b = 8'd3;   10'd95: b = 8'h09; 10'd96: b = 8'h04;
            10'd97: b = 8'd16;  10'd98: b = 8'd3;
            10'd99: b = "G";    10'd101: b = "e";   10'd103: b = "n";  10'd105: b = "e";
            10'd107: b = "r";   10'd109: b = "i";   10'd111: b = "c";
            10'd113: b = 8'd22; 10'd114: b = 8'd3;
            10'd115: b = "C";   10'd117: b = "D";   10'd119: b = "C";  10'd121: b = " ";
            10'd123: b = "S";   10'd125: b = "e";   10'd127: b = "r";  10'd129: b = "i";
            10'd131: b = "a";   10'd133: b = "l";
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic ucrh_dir_t dir_image(input logic [3:0] i);
        ucrh_dir_t e;
        case (i)
            4'd0: e = '{16'h0100, 16'h0000, 16'd0,   8'd18, 1'b1};
            4'd1: e = '{16'h0200, 16'h0000, 16'd18,  8'd75, 1'b1};
            4'd2: e = '{16'h0300, 16'h0000, 16'd93,  8'd4,  1'b1};
            4'd3: e = '{16'h0301, 16'h0409, 16'd97,  8'd16, 1'b1};
            4'd4: e = '{16'h0302, 16'h0409, 16'd113, 8'd22, 1'b1};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

/* design/ucrh_desc_rom.sv */
// ----------------------------------------------------------------------------
// ucrh_desc_rom
// Descriptor byte store, one registered read per cycle.
// ----------------------------------------------------------------------------
module ucrh_desc_rom
    import ucrh_pkg::*;
#(
    parameter int ROM_BYTES        = 256,
    parameter int EP0_PACKET_BYTES = 16
) (
    input  logic                         clk,
    input  logic [$clog2(ROM_BYTES)-1:0] addr,
    output logic [7:0]                   data
);

    // constant contents, read registered; byte 7 of the device descriptor
    // carries the endpoint 0 packet size
    always_ff @(posedge clk)
    begin
        data <= (10'(addr) == 10'd7) ? 8'(EP0_PACKET_BYTES)
              : (10'(addr) < 10'(IMAGE_BYTES)) ? rom_image(10'(addr)) : 8'd0;
    end
endmodule

/* design/usb_cdc_control_request_handler_top.sv */
// Simple requests raise out_valid from ST_SINGLE after acceptance; an unknown
// descriptor walks all DIRECTORY_ENTRIES in ST_SEARCH, then stalls via ST_SINGLE.
// A hit walks entries up to the match, then each packet takes its ROM reads, a
// capture and an emit; output stalls can hold the emit of a packet.
// One request at a time: ready only in idle with no result pending. Reset (rst_n
// low, async) clears address, configuration, line state, restores 57600 8N1.
// ----------------------------------------------------------------------------
// usb_cdc_control_request_handler_top
// Endpoint 0 request decoder with a byte-serial descriptor packetiser.
// ----------------------------------------------------------------------------
module usb_cdc_control_request_handler_top
    import ucrh_pkg::*;
#(
    parameter int EP0_PACKET_BYTES  = 16,
    parameter int ROM_BYTES         = 256,
    parameter int DIRECTORY_ENTRIES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  setup_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] setup_value,
    input  logic [15:0] setup_index,
    input  logic [15:0] setup_length,
    input  logic [55:0] out_stage_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [63:0] packet_low,
    output logic [63:0] packet_high,
    output logic [4:0]  packet_bytes,
    output logic [6:0]  device_address,
    output logic        address_enabled,
    output logic [7:0]  configuration_value,
    output logic [7:0]  line_state,
    output logic        last
);
`include "usb_cdc_control_request_handler_top_macros.svh"

    localparam int AW = $clog2(ROM_BYTES);
    localparam int DW = $clog2(DIRECTORY_ENTRIES);
    // packet size clamped to 8..16, the width of the packet fields
    localparam int PSZ = (EP0_PACKET_BYTES > PKT_FIELD_BYTES) ? PKT_FIELD_BYTES :
                         ((EP0_PACKET_BYTES < 8) ? 8 : EP0_PACKET_BYTES);

    ucrh_state_t state_reg, state_next;

    logic [7:0]  cfg_reg, cfg_next;
    logic [7:0]  ls_reg, ls_next;
    logic [55:0] lc_reg, lc_next;
    logic [7:0]  addr_reg, addr_next;

    // latched request
    logic [15:0] val_reg, val_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;      // remaining reply bytes
    logic [DW:0] dir_reg, dir_next;      // directory walk counter
    logic [AW-1:0] pos_reg, pos_next;    // ROM read address
    logic [4:0]  bcnt_reg, bcnt_next;    // bytes issued in current packet
    logic [4:0]  n_reg, n_next;          // bytes in current packet
    logic        rd_pend_reg, rd_pend_next;
    logic [4:0]  pkts_reg, pkts_next;
    logic [127:0] asm_reg, asm_next;     // packet being assembled

    // output holding register
    logic        ov_reg, ov_next;
    logic [1:0]  kind_reg, kind_next;
    logic [127:0] pkt_reg, pkt_next;
    logic [4:0]  pb_reg, pb_next;
    logic        last_reg, last_next;

    logic [7:0]  rom_data;
    ucrh_dir_t   dent;

    ucrh_desc_rom #(
        .ROM_BYTES        (ROM_BYTES),
        .EP0_PACKET_BYTES (EP0_PACKET_BYTES)
    ) u_rom (
        .clk  (clk),
        .addr (pos_reg),
        .data (rom_data)
    );

    assign dent = dir_image(4'(dir_reg[DW-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= '0;
            ls_reg      <= '0;
            lc_reg      <= LINE_CODING_RESET;
            addr_reg    <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            ls_reg      <= ls_next;
            lc_reg      <= lc_next;
            addr_reg    <= addr_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        dir_reg  <= dir_next;
        pos_reg  <= pos_next;
        bcnt_reg <= bcnt_next;
        n_reg    <= n_next;
        pkts_reg <= pkts_next;
        asm_reg  <= asm_next;
        kind_reg <= kind_next;
        pkt_reg  <= pkt_next;
        pb_reg   <= pb_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        logic [7:0] l;
        logic [3:0] bsel;
        state_next = state_reg;
        cfg_next = cfg_reg; ls_next = ls_reg; lc_next = lc_reg; addr_next = addr_reg;
        val_next = val_reg; idx_next = idx_reg; len_next = len_reg; dir_next = dir_reg;
        pos_next = pos_reg; bcnt_next = bcnt_reg; n_next = n_reg; pkts_next = pkts_reg;
        asm_next = asm_reg;
        rd_pend_next = 1'b0;
        ov_next = ov_reg; kind_next = kind_reg; pkt_next = pkt_reg; pb_next = pb_reg;
        last_next = last_reg;
        in_ready = (state_reg == ST_IDLE) && !ov_reg;
        l = '0;
        bsel = 4'(bcnt_reg - 5'd1);
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kind_next = KIND_STALL; pkt_next = '0; pb_next = '0; last_next = 1'b1;
                    state_next = ST_SINGLE;
                    if (command)
                    begin
                        cfg_next = '0; ls_next = '0; addr_next = '0;
                        kind_next = KIND_RESET;
                    end
                    else if (request_code == REQ_GET_DESC)
                    begin
                        val_next = setup_value; idx_next = setup_index;
                        len_next = (setup_length > 16'd255) ? 8'd255 : setup_length[7:0];
                        dir_next = '0; pkts_next = '0;
                        state_next = ST_SEARCH;
                    end
                    else if (request_code == REQ_SET_ADDRESS)
                    begin
                        addr_next = {1'b1, setup_value[6:0]};
                        kind_next = KIND_STATUS;
                    end
                    else if (request_code == REQ_GET_STATUS)
                    begin
                        kind_next = KIND_IN; pb_next = 5'd2;
                    end
                    else if (request_code == REQ_SET_CONFIG && setup_type == TYPE_STD_OUT)
                    begin
                        cfg_next = setup_value[7:0]; ls_next = '0; kind_next = KIND_STATUS;
                    end
                    else if (request_code == REQ_GET_CONFIG && setup_type == TYPE_STD_IN)
                    begin
                        kind_next = KIND_IN; pkt_next = {120'd0, cfg_reg}; pb_next = 5'd1;
                    end
                    else if (request_code == REQ_GET_LINE_CODE
                             && setup_type == TYPE_CLASS_IN)
                    begin
                        kind_next = KIND_IN; pkt_next = {72'd0, lc_reg}; pb_next = 5'd7;
                    end
                    else if (request_code == REQ_SET_LINE_CODE
                             && setup_type == TYPE_CLASS_OUT)
                    begin
                        lc_next = out_stage_data; kind_next = KIND_STATUS;
                    end
                    else if (request_code == REQ_SET_CTRL_LINE
                             && setup_type == TYPE_CLASS_OUT)
                    begin
                        ls_next = setup_value[7:0]; kind_next = KIND_STATUS;
                    end
                end
            end
            ST_SINGLE:
            begin
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (dir_reg == (DW + 1)'(DIRECTORY_ENTRIES))
                begin
                    kind_next = KIND_STALL; pkt_next = '0; pb_next = '0; last_next = 1'b1;
                    state_next = ST_SINGLE;
                end
                else if (dent.valid && dent.value == val_reg && dent.index == idx_reg)
                begin
                    l = (len_reg > dent.length) ? dent.length : len_reg;
                    len_next = l;
                    pos_next = dent.offset[AW-1:0];
                    n_next = (l < 8'(PSZ)) ? l[4:0] : 5'(PSZ);
                    bcnt_next = '0; asm_next = '0;
                    state_next = ST_FILL;
                end
                else
                    dir_next = dir_reg + 1'b1;
            end
            ST_FILL:
            begin
                // issue a read per cycle, capture it in the following cycle
                if (rd_pend_reg)
                    asm_next[{bsel, 3'b000} +: 8] = rom_data;
                if (bcnt_reg < n_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    bcnt_next = bcnt_reg + 5'd1;
                end
                else if (!ov_reg || out_ready)
                begin
                    kind_next = KIND_IN; pb_next = n_reg; pkt_next = asm_next;
                    len_next = len_reg - 8'(n_reg);
                    pkts_next = pkts_reg + 5'd1;
                    last_next = !((len_reg != 8'(n_reg) || n_reg == 5'(PSZ))
                                  && (pkts_reg + 5'd1 < 5'(MAX_RESULTS)));
                    ov_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_reg)
                    state_next = ST_IDLE;
                else
                begin
                    n_next = (len_reg < 8'(PSZ)) ? len_reg[4:0] : 5'(PSZ);
                    bcnt_next = '0; asm_next = '0;
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // every issued read advances the ROM address, so it ends on the next packet's first byte
    assign out_valid           = ov_reg;
    assign result_kind         = kind_reg;
    assign packet_low          = pkt_reg[63:0];
    assign packet_high         = pkt_reg[127:64];
    assign packet_bytes        = pb_reg;
    assign device_address      = addr_reg[6:0];
    assign address_enabled     = addr_reg[7];
    assign configuration_value = cfg_reg;
    assign line_state          = ls_reg;
    assign last                = last_reg;

    `UCRH_ASSERT(a_busy_no_ready, state_reg != ST_IDLE, !in_ready, "ready while busy")
    `UCRH_ASSERT(a_bytes_range, out_valid, packet_bytes <= 5'(PSZ), "packet too long")
    `UCRH_ASSERT(a_non_in_empty, out_valid && result_kind != KIND_IN,
                 packet_bytes == 5'd0 && last, "non-IN result malformed")
endmodule
